// File: rtl/ppmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmp_pkg
// Shared types, codes and character helpers for the PPM stream parser.
// ----------------------------------------------------------------------------
package ppmp_pkg;

    localparam int DIMENSION_BITS_DEF = 16;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_SIX  = 8'h36;
    localparam logic [7:0] CH_TRE  = 8'h33;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SPC  = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // one input beat as held in the input register
    typedef struct packed {
        logic [7:0] data;
        logic       ended;
    } t_beat;

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == CH_SPC) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

// File: rtl/ppm_header_and_pixel_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_header_and_pixel_parser
// PPM (P6/P3 magic) byte stream parser giving header, pixel and error beats.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one file byte per beat in tdata[7:0]; tuser high marks the
//   end of the stream (tdata is then ignored).
//   Master stream: at most one result beat per input beat. tuser carries the
//   kind (header, pixel, error), tlast flags the final pixel, tdata the fields.
//   A taken input beat passes the input register, then the result register.
//   Throughput: one byte per cycle while the receiver does not stall; the
//   whole per-byte state update is one pass through the step logic.
//   While the receiver stalls, the result register holds and the input
//   register may still take one beat; then tready drops until space frees.
//   Synchronous active-low reset returns the parser to waiting for the magic
//   and empties both registers. After an error, the last pixel or an end of
//   stream, further bytes are taken and dropped until reset.
// ----------------------------------------------------------------------------
module ppm_header_and_pixel_parser
    import ppmp_pkg::*;
#(
    parameter int DIMENSION_BITS = DIMENSION_BITS_DEF,
    localparam int OUT_BITS = 5 * DIMENSION_BITS + 25,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,  // [7:0] data_byte
    input  logic             i_s_axis_tuser,  // [0] end_of_input
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // from bit 0: image_width, image_height, max_colour, binary_format, red,
    // green, blue, column, row, zero fill
    output logic [OUT_W-1:0] o_m_axis_tdata,
    output logic [1:0]       o_m_axis_tuser,  // [1:0] result_kind
    output logic             o_m_axis_tlast   // last_pixel
);

    localparam int D = DIMENSION_BITS;

    logic         r_in_valid;
    t_beat        r_in;
    logic         step;

    logic             res_valid;
    logic [1:0]       res_kind;
    logic [D-1:0]     res_w, res_h, res_maxc, res_col, res_row;
    logic             res_bin, res_last;
    logic [7:0]       res_r, res_g, res_b;
    logic [OUT_W-1:0] res_data;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic [1:0]       r_out_kind;
    logic             r_out_last;

    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.data  <= i_s_axis_tdata;
            r_in.ended <= i_s_axis_tuser;
        end
    end

    ppmp_core #(
        .DIMENSION_BITS(D)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_beat       (r_in),
        .o_res_valid  (res_valid),
        .o_res_kind   (res_kind),
        .o_width      (res_w),
        .o_height     (res_h),
        .o_max_colour (res_maxc),
        .o_binary     (res_bin),
        .o_red        (res_r),
        .o_green      (res_g),
        .o_blue       (res_b),
        .o_column     (res_col),
        .o_row        (res_row),
        .o_last       (res_last)
    );

    assign res_data = {{(OUT_W - OUT_BITS){1'b0}}, res_row, res_col, res_b, res_g, res_r,
                       res_bin, res_maxc, res_h, res_w};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res_valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= res_data;
            r_out_kind <= res_kind;
            r_out_last <= res_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    // last flag only ever rides on a pixel beat
    a_last_is_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser == KIND_PIXEL)
        else $error("tlast on a non-pixel result");

    // back-pressure only when the input register is occupied
    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_valid && r_out_valid && !i_m_axis_tready)
        else $error("input stalled without cause");

    // a held byte is not lost while the output stalls
    a_held_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_m_axis_tready |=> r_in_valid)
        else $error("buffered byte dropped during stall");

endmodule

// File: rtl/ppmp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmp_core
// Parser state and the per-byte step: header fields, comments, pixel grouping.
// ----------------------------------------------------------------------------
module ppmp_core
    import ppmp_pkg::*;
#(
    parameter int DIMENSION_BITS = DIMENSION_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  t_beat                     i_beat,
    output logic                      o_res_valid,
    output logic [1:0]                o_res_kind,
    output logic [DIMENSION_BITS-1:0] o_width,
    output logic [DIMENSION_BITS-1:0] o_height,
    output logic [DIMENSION_BITS-1:0] o_max_colour,
    output logic                      o_binary,
    output logic [7:0]                o_red,
    output logic [7:0]                o_green,
    output logic [7:0]                o_blue,
    output logic [DIMENSION_BITS-1:0] o_column,
    output logic [DIMENSION_BITS-1:0] o_row,
    output logic                      o_last
);

    localparam int D = DIMENSION_BITS;

    localparam logic [3:0] PH_MAGIC1 = 4'd0;
    localparam logic [3:0] PH_MAGIC2 = 4'd1;
    localparam logic [3:0] PH_WIDTH  = 4'd2;
    localparam logic [3:0] PH_HEIGHT = 4'd3;
    localparam logic [3:0] PH_MAXC   = 4'd4;
    localparam logic [3:0] PH_CMT_W  = 4'd5;
    localparam logic [3:0] PH_CMT_H  = 4'd6;
    localparam logic [3:0] PH_CMT_M  = 4'd7;
    localparam logic [3:0] PH_PIXELS = 4'd8;
    localparam logic [3:0] PH_DONE   = 4'd9;
    localparam logic [3:0] PH_ERROR  = 4'd10;
    localparam logic [3:0] CMT_OFS   = 4'd3;

    logic [3:0]   r_phase, n_phase;
    logic [D-1:0] r_acc, n_acc;
    logic         r_seen, n_seen;
    logic [D-1:0] r_w, n_w;
    logic [D-1:0] r_h, n_h;
    logic [D-1:0] r_maxc, n_maxc;
    logic         r_fmt, n_fmt;
    logic [D-1:0] r_x, n_x;
    logic [D-1:0] r_y, n_y;
    logic [1:0]   r_ch, n_ch;
    logic [7:0]   r_red, n_red;
    logic [7:0]   r_grn, n_grn;

    logic [D+3:0] acc_ten;
    logic [D-1:0] acc_sat;
    logic         x_end;
    logic         y_end;

    // acc * 10 + digit, clamped to all ones
    assign acc_ten = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                   + {{D{1'b0}}, i_beat.data[3:0]};
    assign acc_sat = (acc_ten > {4'b0, {D{1'b1}}}) ? {D{1'b1}} : acc_ten[D-1:0];
    assign x_end   = ({1'b0, r_x} + {{D{1'b0}}, 1'b1}) >= {1'b0, r_w};
    assign y_end   = ({1'b0, r_y} + {{D{1'b0}}, 1'b1}) >= {1'b0, r_h};

    always_comb begin
        logic [3:0] ph1;
        logic       hdr;
        logic       hdr_end;
        logic       err;
        n_phase = r_phase;
        n_acc   = r_acc;
        n_seen  = r_seen;
        n_w     = r_w;
        n_h     = r_h;
        n_maxc  = r_maxc;
        n_fmt   = r_fmt;
        n_x     = r_x;
        n_y     = r_y;
        n_ch    = r_ch;
        n_red   = r_red;
        n_grn   = r_grn;
        ph1     = r_phase;
        hdr     = 1'b0;
        hdr_end = 1'b0;
        err     = 1'b0;
        o_res_valid  = 1'b0;
        o_res_kind   = KIND_HEADER;
        o_width      = '0;
        o_height     = '0;
        o_max_colour = '0;
        o_binary     = 1'b0;
        o_red        = '0;
        o_green      = '0;
        o_blue       = '0;
        o_column     = '0;
        o_row        = '0;
        o_last       = 1'b0;

        if (i_step) begin
            case (r_phase)
                PH_MAGIC1: begin
                    if (i_beat.ended) begin
                        err = 1'b1;
                    end else if (i_beat.data == CH_P) begin
                        n_phase = PH_MAGIC2;
                    end else if (!is_space(i_beat.data)) begin
                        err = 1'b1;
                    end
                end
                PH_MAGIC2: begin
                    if (!i_beat.ended && (i_beat.data == CH_SIX || i_beat.data == CH_TRE)) begin
                        n_fmt   = (i_beat.data == CH_SIX);
                        n_acc   = '0;
                        n_seen  = 1'b0;
                        n_phase = PH_WIDTH;
                    end else begin
                        err = 1'b1;
                    end
                end
                PH_WIDTH, PH_HEIGHT, PH_MAXC: begin
                    if (i_beat.ended) begin
                        if (r_phase == PH_MAXC && r_seen) begin
                            hdr     = 1'b1;
                            hdr_end = 1'b1;
                        end else begin
                            err = 1'b1;
                        end
                    end else if (is_digit(i_beat.data)) begin
                        n_acc  = acc_sat;
                        n_seen = 1'b1;
                    end else if (r_seen && r_phase == PH_MAXC) begin
                        // terminator of max colour is swallowed
                        hdr = 1'b1;
                    end else begin
                        if (r_seen) begin
                            if (r_phase == PH_WIDTH) begin
                                n_w = r_acc;
                            end else begin
                                n_h = r_acc;
                            end
                            n_acc  = '0;
                            n_seen = 1'b0;
                            ph1    = r_phase + 4'd1;
                        end
                        if (is_space(i_beat.data)) begin
                            n_phase = ph1;
                        end else if (i_beat.data == CH_HASH) begin
                            n_phase = ph1 + CMT_OFS;
                        end else begin
                            err = 1'b1;
                        end
                    end
                end
                PH_CMT_W, PH_CMT_H, PH_CMT_M: begin
                    if (i_beat.ended) begin
                        err = 1'b1;
                    end else if (i_beat.data == CH_LF) begin
                        n_phase = r_phase - CMT_OFS;
                    end
                end
                PH_PIXELS: begin
                    if (i_beat.ended) begin
                        n_phase = PH_DONE;
                    end else if (r_ch == 2'd0) begin
                        n_red = i_beat.data;
                        n_ch  = 2'd1;
                    end else if (r_ch == 2'd1) begin
                        n_grn = i_beat.data;
                        n_ch  = 2'd2;
                    end else begin
                        n_ch        = 2'd0;
                        o_res_valid = 1'b1;
                        o_res_kind  = KIND_PIXEL;
                        o_red       = r_red;
                        o_green     = r_grn;
                        o_blue      = i_beat.data;
                        o_column    = r_x;
                        o_row       = r_y;
                        o_last      = x_end && y_end;
                        if (x_end && y_end) begin
                            n_phase = PH_DONE;
                        end else if (x_end) begin
                            n_x = '0;
                            n_y = r_y + {{(D-1){1'b0}}, 1'b1};
                        end else begin
                            n_x = r_x + {{(D-1){1'b0}}, 1'b1};
                        end
                    end
                end
                default: begin
                end
            endcase

            if (hdr) begin
                n_maxc       = r_acc;
                n_acc        = '0;
                n_seen       = 1'b0;
                n_x          = '0;
                n_y          = '0;
                n_ch         = 2'd0;
                o_res_valid  = 1'b1;
                o_res_kind   = KIND_HEADER;
                o_width      = r_w;
                o_height     = r_h;
                o_max_colour = r_acc;
                o_binary     = r_fmt;
                n_phase = (!hdr_end && r_w != '0 && r_h != '0) ? PH_PIXELS : PH_DONE;
            end
            if (err) begin
                o_res_valid = 1'b1;
                o_res_kind  = KIND_ERROR;
                n_phase     = PH_ERROR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC1;
            r_acc   <= '0;
            r_seen  <= 1'b0;
            r_w     <= '0;
            r_h     <= '0;
            r_maxc  <= '0;
            r_fmt   <= 1'b0;
            r_x     <= '0;
            r_y     <= '0;
            r_ch    <= 2'd0;
            r_red   <= '0;
            r_grn   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_seen  <= n_seen;
            r_w     <= n_w;
            r_h     <= n_h;
            r_maxc  <= n_maxc;
            r_fmt   <= n_fmt;
            r_x     <= n_x;
            r_y     <= n_y;
            r_ch    <= n_ch;
            r_red   <= n_red;
            r_grn   <= n_grn;
        end
    end

endmodule

// File: tb/tb_ppm_header_and_pixel_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ppm_header_and_pixel_parser
// Feeds one PPM byte stream into the parser and checks every result beat
// against a cycle-free software copy of the header and pixel parsing.
// The stream kind is drawn at random each run: mostly a clean image with
// comments, odd blanks and saturating numbers, otherwise a bad magic, a stray
// character, an early end of stream, an empty image or a saturated width.
// ----------------------------------------------------------------------------
module tb_ppm_header_and_pixel_parser
    import ppmp_pkg::*;
();

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam int unsigned DIM_MAX    = 65535;
    localparam int unsigned LONG_HOLD  = 300;
    localparam int unsigned DRAIN_WAIT = 16;
    localparam int unsigned ITEMS_GOAL = 440;

    // output word, top field first
    typedef struct packed {
        logic [6:0]  fill;
        logic [15:0] row;
        logic [15:0] col;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        bin;
        logic [15:0] maxc;
        logic [15:0] height;
        logic [15:0] width;
    } result_word_t;

    typedef struct packed {
        logic [1:0]   kind;
        logic         last;
        result_word_t f;
    } ppm_result_t;

    typedef enum logic [3:0] {
        PS_MAGIC1, PS_MAGIC2, PS_WIDTH, PS_HEIGHT, PS_MAXC,
        PS_CMT_W, PS_CMT_H, PS_CMT_M, PS_PIXELS, PS_DONE, PS_ERROR
    } parse_phase_t;

    typedef enum int {
        RUN_CLEAN, RUN_BAD_MAGIC, RUN_STRAY, RUN_END_HEADER, RUN_EMPTY,
        RUN_END_MAXC, RUN_SAT_WIDTH, RUN_END_PIXELS
    } run_kind_t;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [7:0]                       i_s_axis_tdata = 8'h00;
    logic                             i_s_axis_tuser = 1'b0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [$bits(result_word_t)-1:0]  o_m_axis_tdata;
    logic [1:0]                       o_m_axis_tuser;
    logic                             o_m_axis_tlast;

    ppm_header_and_pixel_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    t_beat       file_beats[$];
    ppm_result_t expected_results[$];
    int unsigned beats_total = 0;
    int unsigned beats_taken = 0;
    int unsigned mismatches = 0;

    // parser copy
    parse_phase_t phase = PS_MAGIC1;
    int unsigned  acc = 0;
    bit           digit_seen = 1'b0;
    int unsigned  img_width = 0;
    int unsigned  img_height = 0;
    int unsigned  img_maxc = 0;
    bit           is_binary = 1'b0;
    int unsigned  x_pos = 0;
    int unsigned  y_pos = 0;
    int unsigned  channel = 0;
    logic [7:0]   red_hold = 8'h00;
    logic [7:0]   green_hold = 8'h00;

    task automatic raise_error(output ppm_result_t res);
        res = '0;
        res.kind = KIND_ERROR;
        phase = PS_ERROR;
    endtask

    task automatic close_header(output ppm_result_t res, input bit ended);
        img_maxc = acc;
        acc = 0;
        digit_seen = 1'b0;
        x_pos = 0;
        y_pos = 0;
        channel = 0;
        res = '0;
        res.kind = KIND_HEADER;
        res.f.width = img_width[15:0];
        res.f.height = img_height[15:0];
        res.f.maxc = img_maxc[15:0];
        res.f.bin = is_binary;
        phase = (!ended && img_width != 0 && img_height != 0) ? PS_PIXELS : PS_DONE;
    endtask

    task automatic parse_byte(input t_beat beat);
        ppm_result_t res;
        bit          emit;
        bit          white;
        bit          last;
        int unsigned v;
        logic [7:0]  b;
        b = beat.data;
        res = '0;
        emit = 1'b0;
        white = (b == CH_SPC) || (b >= CH_TAB && b <= CH_CR);
        case (phase)
            PS_MAGIC1: begin
                if (beat.ended || !(white || b == CH_P)) begin
                    raise_error(res);
                    emit = 1'b1;
                end else if (b == CH_P) begin
                    phase = PS_MAGIC2;
                end
            end
            PS_MAGIC2: begin
                if (beat.ended || !(b == CH_SIX || b == CH_TRE)) begin
                    raise_error(res);
                    emit = 1'b1;
                end else begin
                    is_binary = (b == CH_SIX);
                    acc = 0;
                    digit_seen = 1'b0;
                    phase = PS_WIDTH;
                end
            end
            PS_WIDTH, PS_HEIGHT, PS_MAXC: begin
                emit = 1'b1;
                if (beat.ended) begin
                    if (phase == PS_MAXC && digit_seen) close_header(res, 1'b1);
                    else raise_error(res);
                end else if (b >= CH_ZERO && b <= CH_NINE) begin
                    v = acc * 10 + (b - CH_ZERO);
                    acc = (v > DIM_MAX) ? DIM_MAX : v;
                    digit_seen = 1'b1;
                    emit = 1'b0;
                end else if (digit_seen && phase == PS_MAXC) begin
                    // whatever byte ends the max colour is swallowed
                    close_header(res, 1'b0);
                end else begin
                    if (digit_seen) begin
                        if (phase == PS_WIDTH) begin
                            img_width = acc;
                            phase = PS_HEIGHT;
                        end else begin
                            img_height = acc;
                            phase = PS_MAXC;
                        end
                        acc = 0;
                        digit_seen = 1'b0;
                    end
                    if (white) begin
                        emit = 1'b0;
                    end else if (b == CH_HASH) begin
                        emit = 1'b0;
                        phase = (phase == PS_WIDTH)  ? PS_CMT_W :
                                (phase == PS_HEIGHT) ? PS_CMT_H : PS_CMT_M;
                    end else begin
                        raise_error(res);
                    end
                end
            end
            PS_CMT_W, PS_CMT_H, PS_CMT_M: begin
                if (beat.ended) begin
                    raise_error(res);
                    emit = 1'b1;
                end else if (b == CH_LF) begin
                    phase = (phase == PS_CMT_W) ? PS_WIDTH :
                            (phase == PS_CMT_H) ? PS_HEIGHT : PS_MAXC;
                end
            end
            PS_PIXELS: begin
                if (beat.ended) begin
                    phase = PS_DONE;
                end else if (channel == 0) begin
                    red_hold = b;
                    channel = 1;
                end else if (channel == 1) begin
                    green_hold = b;
                    channel = 2;
                end else begin
                    channel = 0;
                    last = (x_pos + 1 >= img_width) && (y_pos + 1 >= img_height);
                    res.kind = KIND_PIXEL;
                    res.last = last;
                    res.f.red = red_hold;
                    res.f.green = green_hold;
                    res.f.blue = b;
                    res.f.col = x_pos[15:0];
                    res.f.row = y_pos[15:0];
                    emit = 1'b1;
                    if (last) begin
                        phase = PS_DONE;
                    end else if (x_pos + 1 >= img_width) begin
                        x_pos = 0;
                        y_pos = (y_pos + 1) & DIM_MAX;
                    end else begin
                        x_pos = (x_pos + 1) & DIM_MAX;
                    end
                end
            end
            default: ;
        endcase
        if (emit) expected_results.push_back(res);
    endtask

    // ---- stream building ----
    task automatic put_byte(input logic [7:0] b);
        file_beats.push_back('{data: b, ended: 1'b0});
    endtask

    task automatic put_end();
        file_beats.push_back('{data: 8'($urandom), ended: 1'b1});
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic put_blanks(input int unsigned n);
        int unsigned k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 5);
            put_byte((k == 5) ? CH_SPC : CH_TAB + 8'(k));
        end
    endtask

    task automatic put_comment();
        logic [7:0] b;
        put_byte(CH_HASH);
        repeat ($urandom_range(0, 4)) begin
            do b = 8'($urandom); while (b == CH_LF);
            put_byte(b);
        end
        put_byte(CH_LF);
    endtask

    task automatic put_noise(input int unsigned n);
        repeat (n) put_byte(8'($urandom));
    endtask

    task automatic build_stream();
        run_kind_t   run;
        int unsigned r;
        int unsigned cut;
        int unsigned img_w;
        int unsigned img_h;
        int unsigned n_bytes;
        logic [7:0]  b;
        string       txt;
        r = $urandom_range(0, 19);
        run = (r < 7) ? run_kind_t'(r + 1) : RUN_CLEAN;
        cut = $urandom_range(0, 3);
        img_w = $urandom_range(1, 16);
        img_h = $urandom_range(140 / img_w + 1, 150 / img_w);

        put_byte(CH_SPC);
        put_byte(CH_TAB);
        put_byte(CH_LF);
        put_byte(CH_VT);
        put_byte(CH_FF);
        put_byte(CH_CR);
        if (run == RUN_BAD_MAGIC) begin
            if (cut[0]) begin
                do b = 8'($urandom);
                while (b == CH_P || b == CH_SPC || (b >= CH_TAB && b <= CH_CR));
                put_byte(b);
            end else begin
                put_byte(CH_P);
                do b = 8'($urandom); while (b == CH_SIX || b == CH_TRE);
                put_byte(b);
            end
            return;
        end
        put_byte(CH_P);
        if (run == RUN_END_HEADER && cut == 0) begin
            put_end();
            return;
        end
        put_byte($urandom_range(0, 1) ? CH_SIX : CH_TRE);
        if (run == RUN_END_HEADER && cut == 1) begin
            put_byte(CH_HASH);
            put_end();
            return;
        end
        put_comment();

        if (run == RUN_SAT_WIDTH) txt = "987654";
        else if (run == RUN_EMPTY && cut[0]) txt = "0";
        else txt = $sformatf("0%0d", img_w);
        put_text(txt);
        if (run == RUN_END_HEADER && cut == 2) begin
            put_end();
            return;
        end
        if (run == RUN_STRAY && cut[0]) begin
            // stray byte straight after the width digits
            do b = 8'($urandom);
            while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_HASH || b == CH_SPC ||
                   (b >= CH_TAB && b <= CH_CR));
            put_byte(b);
            return;
        end
        put_comment();   // hash right after the digits opens a comment
        if (run == RUN_STRAY) begin
            put_byte($urandom_range(0, 1) ? 8'h2D : 8'h2B);   // sign before height
            return;
        end

        if (run == RUN_EMPTY && !cut[0]) txt = "0";
        else if (run == RUN_SAT_WIDTH) txt = "1";
        else txt = $sformatf("%0d", img_h);
        put_text(txt);
        if (run == RUN_END_HEADER && cut == 3) begin
            put_end();
            return;
        end
        put_byte(CH_TAB);
        if ($urandom_range(0, 1)) put_comment();
        put_blanks($urandom_range(0, 2));

        r = $urandom_range(0, 3);
        if (r == 0) txt = "9999999";
        else if (r == 1) txt = "65535";
        else if (r == 2) txt = "255";
        else txt = $sformatf("%0d", $urandom_range(1, 65535));
        put_text(txt);
        if (run == RUN_END_MAXC) begin
            put_end();
            return;
        end
        put_blanks(1);

        n_bytes = (run == RUN_SAT_WIDTH) ? 420 : 3 * img_w * img_h;
        if (run == RUN_END_PIXELS) n_bytes = $urandom_range(1, n_bytes - 1);
        if (run == RUN_EMPTY) n_bytes = 0;
        if (n_bytes >= 6) begin
            // all-zero and all-ones pixels first
            repeat (3) put_byte(8'h00);
            repeat (3) put_byte(8'hFF);
            n_bytes -= 6;
        end
        put_noise(n_bytes);
        if (run == RUN_END_PIXELS || run == RUN_SAT_WIDTH) put_end();
    endtask

    // ---- byte sender: bursts with random gaps ----
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin : byte_sender
        t_beat nb;
        bit    offer;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            offer = !i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                parse_byte('{data: i_s_axis_tdata, ended: i_s_axis_tuser});
                beats_taken++;
                offer = 1'b1;
            end
            if (offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (file_beats.size() > 0) begin
                    nb = file_beats.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= nb.data;
                    i_s_axis_tuser <= nb.ended;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 32);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1, 2:    gap_left = $urandom_range(1, 3);
                            default: gap_left = $urandom_range(4, 12);
                        endcase
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---- result receiver: stall modes plus one long hold ----
    int unsigned rx_cycles = 0;
    int unsigned rx_mode = 0;
    int unsigned mode_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            rx_cycles++;
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!hold_done) begin
                // not ready until the first result, then a long hold on it so
                // the parser backs up into its input
                i_m_axis_tready <= 1'b0;
                if (o_m_axis_tvalid) begin
                    hold_done = 1'b1;
                    hold_left = LONG_HOLD;
                end
            end else begin
                if (mode_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    0:       i_m_axis_tready <= 1'b1;
                    1:       i_m_axis_tready <= 1'($urandom);
                    2:       i_m_axis_tready <= ($urandom_range(0, 9) == 0);
                    default: i_m_axis_tready <= (rx_cycles % 4 != 0);
                endcase
            end
        end
    end

    // ---- result checker ----
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_checker
        ppm_result_t seen;
        ppm_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen.kind = o_m_axis_tuser;
            seen.last = o_m_axis_tlast;
            seen.f = o_m_axis_tdata;
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with none expected, expected nothing, actual kind %0d",
                         $time, seen.kind);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, seen.kind);
                check_field("last_pixel", want.last, seen.last);
                check_field("width", want.f.width, seen.f.width);
                check_field("height", want.f.height, seen.f.height);
                check_field("max_colour", want.f.maxc, seen.f.maxc);
                check_field("binary", want.f.bin, seen.f.bin);
                check_field("red", want.f.red, seen.f.red);
                check_field("green", want.f.green, seen.f.green);
                check_field("blue", want.f.blue, seen.f.blue);
                check_field("column", want.f.col, seen.f.col);
                check_field("row", want.f.row, seen.f.row);
                check_field("fill", want.f.fill, seen.f.fill);
            end
        end
    end

    initial begin
        build_stream();
        // short runs are padded with bytes that the parser drops
        if (file_beats.size() < ITEMS_GOAL) put_noise(ITEMS_GOAL - file_beats.size());
        // trailing bytes and a stream end, dropped unless still in the header
        put_noise($urandom_range(2, 12));
        put_end();
        put_noise(2);
        beats_total = file_beats.size();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (beats_taken < beats_total) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
